// File: rtl/core/rpd_pkg.sv
// Shared constants, codes and types for the remote packet decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpd_pkg;

  localparam int PACKET_BYTES = 12;
  localparam int POS_W        = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] DONE_POS = POS_W'(PACKET_BYTES);

  localparam logic [7:0] TRAILER_VALUE = 8'hA5;
  localparam int KIND_CHANNELS_BIT = 0;
  localparam int KIND_BUTTONS_BIT  = 3;

  localparam int BUTTONS_AT  = 1;
  localparam int AUX_AT      = 4;
  localparam int STEER_AT    = 6;
  localparam int THROTTLE_AT = 8;
  localparam int ID_AT       = 10;

  localparam int CFG_IDX_W = 2;
  localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd25;
  localparam logic [15:0] LOW_THRESHOLD_RESET  = 16'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THRESHOLD = 2'd0,
    CFG_LOW_THRESHOLD  = 2'd1
  } rpd_cfg_idx_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_begin;
  } rpd_item_t;

  typedef struct packed {
    logic [15:0] high;
    logic [15:0] low;
  } rpd_thresh_t;

  typedef struct packed {
    logic left;
    logic right;
    logic forward;
    logic backward;
  } rpd_flags_t;

  typedef struct packed {
    logic        trailer_ok;
    rpd_flags_t  flags;
    logic [7:0]  button_mask;
    logic [7:0]  packet_id;
    logic [15:0] aux_channel;
    logic [15:0] steer_channel;
    logic [15:0] throttle_channel;
  } rpd_result_t;

endpackage

`default_nettype wire

// File: rtl/core/rpd_cfg_regs.sv
// Threshold registers written through the configuration channel.
// Depends on rpd_pkg.
`default_nettype none

module rpd_cfg_regs
  import rpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  output rpd_thresh_t               thresh
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.high <= HIGH_THRESHOLD_RESET;
      thresh.low  <= LOW_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (rpd_cfg_idx_t'(cfg_index))
        CFG_HIGH_THRESHOLD: thresh.high <= cfg_data;
        CFG_LOW_THRESHOLD:  thresh.low  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rpd_in_reg.sv
// Input register for received bytes; holds a request until the decode stage takes it.
// Depends on rpd_pkg.
`default_nettype none

module rpd_in_reg
  import rpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       packet_begin,
  input  wire logic       advance,
  output logic            item_valid,
  output rpd_item_t       item
);

  logic load;

  assign load       = !item_valid || advance;
  assign byte_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && byte_valid) begin
      item.rx_byte      <= rx_byte;
      item.packet_begin <= packet_begin;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rpd_decode.sv
// Byte position tracking, packet buffer, trailer check and latched values.
// Depends on rpd_pkg.
`default_nettype none

module rpd_decode
  import rpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire rpd_item_t   item,
  input  wire rpd_thresh_t thresh,
  input  wire logic        out_free,
  output logic             advance,
  output logic             res_valid,
  output rpd_result_t      res
);

  logic [7:0]       byte_store [PACKET_BYTES];
  logic [POS_W-1:0] pos;
  rpd_flags_t       flags;
  logic [7:0]       buttons;
  logic [7:0]       id;
  logic [15:0]      aux;
  logic [15:0]      steer;
  logic [15:0]      throttle;

  logic [POS_W-1:0] eff_pos;
  logic [POS_W-1:0] pos_next;
  logic             in_range;
  logic             is_last;
  logic             commit;
  logic             is_chan;
  logic             is_btn;
  logic [15:0]      aux_new;
  logic [15:0]      steer_new;
  logic [15:0]      throttle_new;
  rpd_flags_t       flags_new;
  rpd_flags_t       flags_next;
  logic [7:0]       buttons_next;
  logic [7:0]       id_next;
  logic [15:0]      aux_next;
  logic [15:0]      steer_next;
  logic [15:0]      throttle_next;

  always_comb begin
    eff_pos  = item.packet_begin ? '0 : pos;
    in_range = eff_pos < DONE_POS;
    is_last  = eff_pos == LAST_POS;
    advance  = item_valid && (!is_last || out_free);
    res_valid = advance && is_last;
    commit   = res_valid && (item.rx_byte == TRAILER_VALUE);

    if (!in_range) begin
      pos_next = eff_pos;
    end else if (is_last) begin
      pos_next = DONE_POS;
    end else begin
      pos_next = eff_pos + POS_W'(1);
    end

    is_chan = byte_store[0][KIND_CHANNELS_BIT];
    is_btn  = byte_store[0][KIND_BUTTONS_BIT];

    aux_new      = {byte_store[AUX_AT + 1], byte_store[AUX_AT]};
    steer_new    = {byte_store[STEER_AT + 1], byte_store[STEER_AT]};
    throttle_new = {byte_store[THROTTLE_AT + 1], byte_store[THROTTLE_AT]};

    // Above-high wins when the thresholds cross.
    flags_new.right    = steer_new > thresh.high;
    flags_new.left     = !flags_new.right && (steer_new < thresh.low);
    flags_new.forward  = throttle_new > thresh.high;
    flags_new.backward = !flags_new.forward && (throttle_new < thresh.low);

    flags_next    = flags;
    buttons_next  = buttons;
    id_next       = id;
    aux_next      = aux;
    steer_next    = steer;
    throttle_next = throttle;
    if (commit) begin
      if (is_chan) begin
        aux_next      = aux_new;
        steer_next    = steer_new;
        throttle_next = throttle_new;
        flags_next    = flags_new;
      end else if (is_btn) begin
        buttons_next = byte_store[BUTTONS_AT];
      end
      id_next = byte_store[ID_AT];
    end

    res.trailer_ok       = commit;
    res.flags            = flags_next;
    res.button_mask      = buttons_next;
    res.packet_id        = id_next;
    res.aux_channel      = aux_next;
    res.steer_channel    = steer_next;
    res.throttle_channel = throttle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      flags    <= '0;
      buttons  <= '0;
      id       <= '0;
      aux      <= '0;
      steer    <= '0;
      throttle <= '0;
    end else if (advance) begin
      pos      <= pos_next;
      flags    <= flags_next;
      buttons  <= buttons_next;
      id       <= id_next;
      aux      <= aux_next;
      steer    <= steer_next;
      throttle <= throttle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_range) begin
      byte_store[eff_pos] <= item.rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/remote_packet_decoder.sv
// Remote packet decoder: 12-byte packets in, one status request per packet out.
// A packet's result is valid once its last byte has passed the input and result registers.
// Throughput: one byte per cycle; the input register, decode logic and result register
// each pass a request every cycle unless the result channel stalls.
// Reset: synchronous, active high; clears position and latched values; thresholds to 25/5.
`default_nettype none

module remote_packet_decoder
  import rpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // byte channel
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 packet_begin,
  // result channel
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic                      trailer_ok,
  output logic                      steer_left,
  output logic                      steer_right,
  output logic                      drive_forward,
  output logic                      drive_backward,
  output logic [7:0]                button_mask,
  output logic [7:0]                packet_id,
  output logic [15:0]               aux_channel,
  output logic [15:0]               steer_channel,
  output logic [15:0]               throttle_channel,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  rpd_thresh_t thresh;
  rpd_item_t   item;
  rpd_result_t res;
  rpd_result_t out_res;
  logic        item_valid;
  logic        advance;
  logic        res_valid;
  logic        out_free;

  // Thresholds used by the direction classifier.
  rpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thresh    (thresh)
  );

  // Hold each incoming byte until the decode stage consumes it.
  rpd_in_reg u_in (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .rx_byte      (rx_byte),
    .packet_begin (packet_begin),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  // Only the last byte of a packet needs room in the result register; all
  // other bytes advance freely so the link keeps streaming.
  rpd_decode u_dec (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .thresh     (thresh),
    .out_free   (out_free),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register: load a new request when empty or when the current one
  // is being taken this cycle.
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  assign trailer_ok       = out_res.trailer_ok;
  assign steer_left       = out_res.flags.left;
  assign steer_right      = out_res.flags.right;
  assign drive_forward    = out_res.flags.forward;
  assign drive_backward   = out_res.flags.backward;
  assign button_mask      = out_res.button_mask;
  assign packet_id        = out_res.packet_id;
  assign aux_channel      = out_res.aux_channel;
  assign steer_channel    = out_res.steer_channel;
  assign throttle_channel = out_res.throttle_channel;

  // A held byte is only ever blocked by a full, stalled result register.
  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |-> result_valid && result_stall)
    else $error("byte held without a blocked result");

  // A new result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result produced while result register blocked");

  // Opposite direction flags are never set together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(steer_left && steer_right) && !(drive_forward && drive_backward))
    else $error("conflicting direction flags");

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for remote_packet_decoder: feeds byte requests, predicts each packet's
// result from the accepted bytes and checks every result request field by field.
// Depends on rpd_pkg and the remote_packet_decoder RTL only.

module tb;
  import rpd_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_PACKETS = 15;

  // ---------------------------------------------------------------------------
  // Block ports; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 byte_valid   = 1'b0;
  logic                 byte_stall;
  logic [7:0]           rx_byte      = '0;
  logic                 packet_begin = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 trailer_ok;
  logic                 steer_left;
  logic                 steer_right;
  logic                 drive_forward;
  logic                 drive_backward;
  logic [7:0]           button_mask;
  logic [7:0]           packet_id;
  logic [15:0]          aux_channel;
  logic [15:0]          steer_channel;
  logic [15:0]          throttle_channel;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_HIGH_THRESHOLD;
  logic [15:0]          cfg_data     = '0;

  remote_packet_decoder uut (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .rx_byte          (rx_byte),
    .packet_begin     (packet_begin),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .trailer_ok       (trailer_ok),
    .steer_left       (steer_left),
    .steer_right      (steer_right),
    .drive_forward    (drive_forward),
    .drive_backward   (drive_backward),
    .button_mask      (button_mask),
    .packet_id        (packet_id),
    .aux_channel      (aux_channel),
    .steer_channel    (steer_channel),
    .throttle_channel (throttle_channel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow: thresholds, packet buffer, write position and latched values,
  // advanced once per accepted byte request.
  // ---------------------------------------------------------------------------
  logic [15:0]      thr_high      = HIGH_THRESHOLD_RESET;
  logic [15:0]      thr_low       = LOW_THRESHOLD_RESET;
  logic [7:0]       packet_buf [PACKET_BYTES];
  logic [POS_W-1:0] write_pos     = '0;
  rpd_flags_t       flags_held    = '0;
  logic [7:0]       buttons_held  = '0;
  logic [7:0]       id_held       = '0;
  logic [15:0]      aux_held      = '0;
  logic [15:0]      steer_held    = '0;
  logic [15:0]      throttle_held = '0;

  rpd_result_t packet_results [$];   // results owed by the block, oldest first
  rpd_item_t   pending_bytes [$];    // byte requests not yet offered

  // Idling knobs, in percent of cycles, set per phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Long receiver hold-off: the sequencer asks, the stall process counts it out.
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  bit byte_taken  = 1'b0;
  int failures    = 0;
  int cycle_count = 0;

  // Advance the shadow by one accepted byte; owe a result when a packet completes.
  task automatic decode_byte(input logic [7:0] b, input logic begin_mark);
    rpd_result_t r;
    if (begin_mark)
      write_pos = '0;
    // Past the last position: drop everything until the next begin mark.
    if (write_pos >= DONE_POS)
      return;
    packet_buf[write_pos] = b;
    if (write_pos != LAST_POS) begin
      write_pos++;
      return;
    end
    write_pos = DONE_POS;

    r.trailer_ok = (packet_buf[PACKET_BYTES-1] == TRAILER_VALUE);
    if (r.trailer_ok) begin
      if (packet_buf[0][KIND_CHANNELS_BIT]) begin
        aux_held      = {packet_buf[AUX_AT+1], packet_buf[AUX_AT]};
        steer_held    = {packet_buf[STEER_AT+1], packet_buf[STEER_AT]};
        throttle_held = {packet_buf[THROTTLE_AT+1], packet_buf[THROTTLE_AT]};
        // The "above high" test wins when the thresholds cross.
        flags_held.right    = steer_held > thr_high;
        flags_held.left     = !flags_held.right && (steer_held < thr_low);
        flags_held.forward  = throttle_held > thr_high;
        flags_held.backward = !flags_held.forward && (throttle_held < thr_low);
      end else if (packet_buf[0][KIND_BUTTONS_BIT]) begin
        buttons_held = packet_buf[BUTTONS_AT];
      end
      id_held = packet_buf[ID_AT];
    end
    r.flags            = flags_held;
    r.button_mask      = buttons_held;
    r.packet_id        = id_held;
    r.aux_channel      = aux_held;
    r.steer_channel    = steer_held;
    r.throttle_channel = throttle_held;
    packet_results.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rpd_result_t want;
    byte_taken = !rst && byte_valid && !byte_stall;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (packet_results.size() == 0) begin
          $display("%0t ns: result request with none expected, got packet_id %h",
                   $time, packet_id);
          failures++;
        end else begin
          want = packet_results.pop_front();
          check_field("trailer_ok", 16'(want.trailer_ok), 16'(trailer_ok));
          check_field("steer_left", 16'(want.flags.left), 16'(steer_left));
          check_field("steer_right", 16'(want.flags.right), 16'(steer_right));
          check_field("drive_forward", 16'(want.flags.forward), 16'(drive_forward));
          check_field("drive_backward", 16'(want.flags.backward), 16'(drive_backward));
          check_field("button_mask", 16'(want.button_mask), 16'(button_mask));
          check_field("packet_id", 16'(want.packet_id), 16'(packet_id));
          check_field("aux_channel", want.aux_channel, aux_channel);
          check_field("steer_channel", want.steer_channel, steer_channel);
          check_field("throttle_channel", want.throttle_channel, throttle_channel);
        end
      end
      if (byte_taken)
        decode_byte(rx_byte, packet_begin);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HIGH_THRESHOLD: thr_high = cfg_data;
          CFG_LOW_THRESHOLD:  thr_low  = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver: advance to the next request only once the current one was taken
  // (or none is offered); hold the payload steady while stalled. Idle gaps are
  // decided without looking at byte_stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rpd_item_t req;
    if (!byte_valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_bytes.pop_front();
        byte_valid   <= 1'b1;
        rx_byte      <= req.rx_byte;
        packet_begin <= req.packet_begin;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall: a long hold-off when asked, random stalls otherwise.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic mark);
    rpd_item_t req;
    req.rx_byte      = b;
    req.packet_begin = mark;
    pending_bytes.push_back(req);
  endtask

  // Channel value biased onto the threshold edges and the range ends.
  function automatic logic [15:0] channel_value();
    case ($urandom_range(5))
      0:       return thr_high + 16'($urandom_range(2)) - 16'd1;
      1:       return thr_low + 16'($urandom_range(2)) - 16'd1;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One random packet: mostly well formed, some bad trailers, some cut short,
  // some followed by stray bytes.
  task automatic queue_packet();
    logic [7:0]  pkt [PACKET_BYTES];
    logic [15:0] steer;
    logic [15:0] throttle;
    int          kind;
    int          len;
    foreach (pkt[i])
      pkt[i] = 8'($urandom);
    kind = $urandom_range(19);
    // Channel packets dominate; the rest split among buttons, both bits and neither.
    pkt[0][KIND_CHANNELS_BIT] = (kind < 8) || (kind >= 14 && kind < 17);
    pkt[0][KIND_BUTTONS_BIT]  = (kind >= 8 && kind < 17);
    steer    = channel_value();
    throttle = channel_value();
    {pkt[STEER_AT+1], pkt[STEER_AT]}       = steer;
    {pkt[THROTTLE_AT+1], pkt[THROTTLE_AT]} = throttle;
    if ($urandom_range(7) != 0)
      pkt[PACKET_BYTES-1] = TRAILER_VALUE;
    // A few packets break off early; the next begin mark restarts the position.
    len = ($urandom_range(15) == 0) ? $urandom_range(1, PACKET_BYTES - 1) : PACKET_BYTES;
    for (int i = 0; i < len; i++)
      queue_byte(pkt[i], i == 0);
    // Stray bytes, now and then with a begin mark of their own.
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3))
        queue_byte(8'($urandom), 1'($urandom_range(3) == 0));
  endtask

  task automatic write_register(input rpd_cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is out and every result is in, then let the
  // pipeline settle past its latency (a cut-off packet owes no result).
  task automatic wait_quiet();
    while (pending_bytes.size() != 0 || byte_valid || packet_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] high, input logic [15:0] low,
                           input int send_pct, input int recv_pct, input bit hold);
    write_register(CFG_HIGH_THRESHOLD, high);
    write_register(CFG_LOW_THRESHOLD, low);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    if (hold)
      holds_asked++;
    repeat (PHASE_PACKETS)
      queue_packet();
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] chan_pkt [PACKET_BYTES];
    logic [7:0] btn_pkt [PACKET_BYTES];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: the first packet after reset carries no begin mark. Both kind bits
    // set (channels win, buttons stay put), aux at full scale, steer just under the
    // low threshold, throttle just over the high one.
    chan_pkt = '{8'h09, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
                 8'h04, 8'h00, 8'h1A, 8'h00, 8'hFF, TRAILER_VALUE};
    foreach (chan_pkt[i])
      queue_byte(chan_pkt[i], 1'b0);
    // Drop a byte past the end of the packet.
    queue_byte(8'h5A, 1'b0);
    // Button packet with a trailer one off: nothing latched may change.
    btn_pkt = '{8'h08, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, TRAILER_VALUE - 8'd1};
    foreach (btn_pkt[i])
      queue_byte(btn_pkt[i], i == 0);
    queue_byte(8'h00, 1'b0);
    wait_quiet();

    // Random phases: thresholds at reset values, extremes, crossed and mid-range,
    // each with its own idling pattern.
    run_phase(HIGH_THRESHOLD_RESET, LOW_THRESHOLD_RESET, 0, 0, 1'b0);
    run_phase(16'hFFFF, 16'h0000, 78, 0, 1'b0);
    run_phase(16'h0000, 16'hFFFF, 0, 78, 1'b0);
    run_phase(16'h0000, 16'h0000, 12, 12, 1'b0);
    // Hold the result side off long enough for the block to back up its input.
    run_phase(16'hFFFF, 16'hFFFF, 0, 0, 1'b1);
    run_phase(16'($urandom), 16'($urandom), 78, 0, 1'b0);
    run_phase(16'd100, 16'd2000, 0, 78, 1'b0);
    run_phase(16'd1000, 16'd300, 12, 12, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 0, 0, 1'b0);

    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: end the run as a failure once the cycle limit is reached.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rpd_pkg.sv
rtl/core/rpd_cfg_regs.sv
rtl/core/rpd_in_reg.sv
rtl/core/rpd_decode.sv
rtl/core/remote_packet_decoder.sv
test/tb.sv
